### hdl/asfu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asfu_pkg
// Shared widths, types and CRC constants of the angle sensor frame unwrapper.
// ----------------------------------------------------------------------------
package asfu_pkg;

   localparam int BYTE_BITS   = 8;
   localparam int WORD_BITS   = 24;
   localparam int STATUS_BITS = 3;
   localparam int RAW_BITS    = 21;
   localparam int TOTAL_BITS  = 38;

   typedef logic [BYTE_BITS-1:0]   byte_type;
   typedef logic [WORD_BITS-1:0]   word_type;
   typedef logic [STATUS_BITS-1:0] status_type;
   typedef logic [RAW_BITS-1:0]    raw_type;
   typedef logic [TOTAL_BITS-1:0]  total_type;

   typedef enum logic {
      ACTION_SAMPLE = 1'b0,
      ACTION_HOME   = 1'b1
   } action_type;

   // CRC-8, poly 0x07, init 0, MSB first: contribution of each word bit
   // (index 0 = LSB) is x^(i+8) mod P.
   localparam byte_type CRC_COLUMNS [WORD_BITS] = '{
      8'h07, 8'h0E, 8'h1C, 8'h38, 8'h70, 8'hE0, 8'hC7, 8'h89,
      8'h15, 8'h2A, 8'h54, 8'hA8, 8'h57, 8'hAE, 8'h5B, 8'hB6,
      8'h6B, 8'hD6, 8'hAB, 8'h51, 8'hA2, 8'h43, 8'h86, 8'h0B
   };

   typedef struct packed {
      raw_type    frame_angle;
      status_type sensor_status;
      logic       crc_ok;
   } frame_fields_type;

   function automatic byte_type crc8_word(word_type word);
      byte_type crc;
      crc = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (word[i]) begin
            crc = crc ^ CRC_COLUMNS[i];
         end
      end
      return crc;
   endfunction

endpackage
`default_nettype wire

### hdl/asfu_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asfu_req_if
// Input channel: one returned sensor frame and the requested action.
// ----------------------------------------------------------------------------
interface asfu_req_if
   import asfu_pkg::*;
;
   logic       valid;
   logic       ready;
   logic       action;
   byte_type   angle_high_byte;
   byte_type   angle_mid_byte;
   byte_type   angle_low_status_byte;
   byte_type   frame_crc;

   modport source (
      output valid, action, angle_high_byte, angle_mid_byte,
             angle_low_status_byte, frame_crc,
      input  ready
   );

   modport sink (
      input  valid, action, angle_high_byte, angle_mid_byte,
             angle_low_status_byte, frame_crc,
      output ready
   );
endinterface
`default_nettype wire

### hdl/asfu_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asfu_rsp_if
// Result channel: multi-turn angle, CRC check, frame angle and status.
// ----------------------------------------------------------------------------
interface asfu_rsp_if
   import asfu_pkg::*;
;
   logic       valid;
   logic       ready;
   total_type  total_angle;
   logic       crc_ok;
   raw_type    frame_angle;
   status_type sensor_status;

   modport source (
      output valid, total_angle, crc_ok, frame_angle, sensor_status,
      input  ready
   );

   modport sink (
      input  valid, total_angle, crc_ok, frame_angle, sensor_status,
      output ready
   );
endinterface
`default_nettype wire

### hdl/asfu_frame_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asfu_frame_decode
// Unpacks angle and status from the three data bytes and checks the CRC-8.
// ----------------------------------------------------------------------------
module asfu_frame_decode
   import asfu_pkg::*;
#(
   parameter int ANGLE_BITS = 21
) (
   input  byte_type         angle_high_byte,
   input  byte_type         angle_mid_byte,
   input  byte_type         angle_low_status_byte,
   input  byte_type         frame_crc,
   output frame_fields_type fields
);

   word_type              word;
   logic [ANGLE_BITS-1:0] angle;

   assign word  = {angle_high_byte, angle_mid_byte, angle_low_status_byte};
   assign angle = ANGLE_BITS'(word[WORD_BITS-1:STATUS_BITS]);

   assign fields.frame_angle   = RAW_BITS'(angle);
   assign fields.sensor_status = word[STATUS_BITS-1:0];
   assign fields.crc_ok        = (crc8_word(word) == frame_crc);

endmodule
`default_nettype wire

### hdl/asfu_unwrap.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asfu_unwrap
// Turn counter, last angle and home offset; forms the multi-turn total.
// ----------------------------------------------------------------------------
module asfu_unwrap
   import asfu_pkg::*;
#(
   parameter int ANGLE_BITS = 21,
   parameter int TURN_BITS  = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             update_en,
   input  action_type       action,
   input  frame_fields_type fields,
   output total_type        total_angle
);

   localparam logic signed [ANGLE_BITS:0]  HALF_TURN = (ANGLE_BITS+1)'(1) << (ANGLE_BITS-1);
   localparam logic signed [ANGLE_BITS:0]  NEG_HALF  = -HALF_TURN;
   localparam logic signed [TURN_BITS-1:0] TURN_ONE  = TURN_BITS'(1);
   localparam logic signed [TURN_BITS-1:0] TURN_MAX  = {1'b0, {(TURN_BITS-1){1'b1}}};
   localparam logic signed [TURN_BITS-1:0] TURN_MIN  = {1'b1, {(TURN_BITS-1){1'b0}}};

   logic        [ANGLE_BITS-1:0] last_ff, last_in;
   logic        [ANGLE_BITS-1:0] home_ff, home_in;
   logic signed [TURN_BITS-1:0]  turn_ff, turn_in;

   logic        [ANGLE_BITS-1:0] angle;
   logic signed [ANGLE_BITS:0]   diff;
   total_type                    turn_ext;
   total_type                    turn_scaled;

   assign angle = ANGLE_BITS'(fields.frame_angle);
   assign diff  = signed'({1'b0, angle}) - signed'({1'b0, last_ff});

   always_comb begin
      last_in = last_ff;
      home_in = home_ff;
      turn_in = turn_ff;
      if (fields.crc_ok) begin
         if (action == ACTION_HOME) begin
            turn_in = '0;
            home_in = angle;
         end else begin
            if (diff > HALF_TURN) begin
               if (turn_ff != TURN_MIN) begin
                  turn_in = turn_ff - TURN_ONE;
               end
            end else if (diff < NEG_HALF) begin
               if (turn_ff != TURN_MAX) begin
                  turn_in = turn_ff + TURN_ONE;
               end
            end
            last_in = angle;
         end
      end
   end

   assign turn_ext    = TOTAL_BITS'(turn_in);
   assign turn_scaled = turn_ext << ANGLE_BITS;
   assign total_angle = turn_scaled + TOTAL_BITS'(last_in) - TOTAL_BITS'(home_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
         home_ff <= '0;
         turn_ff <= '0;
      end else if (update_en) begin
         last_ff <= last_in;
         home_ff <= home_in;
         turn_ff <= turn_in;
      end
   end

   a_crc_fail_holds: assert property (@(posedge clock) disable iff (reset)
      update_en && !fields.crc_ok |=> $stable(last_ff) && $stable(home_ff) && $stable(turn_ff))
      else $error("state changed on a frame with a bad CRC");

   a_home_clears_turns: assert property (@(posedge clock) disable iff (reset)
      update_en && fields.crc_ok && action == ACTION_HOME |=> turn_ff == '0 && $stable(last_ff))
      else $error("home item did not clear the turn counter");

endmodule
`default_nettype wire

### hdl/angle_sensor_frame_unwrapper.sv
`default_nettype none
// ----------------------------------------------------------------------------
// angle_sensor_frame_unwrapper
// Multi-turn unwrapper for magnetic angle sensor frames.
//
// req_chan carries one frame (three data bytes and the received CRC) and an
// action: sample or set home. rsp_chan returns one result per frame: total
// angle relative to home, CRC flag, frame angle and status. A transfer on
// req_chan is registered into the input register, then decoded and unwrapped
// into the result register that drives rsp_chan; a stall on rsp_chan can hold
// a frame in either register. Throughput is one frame per cycle unless
// rsp_chan stalls; the turn counter update is a single register-to-register
// step, so consecutive frames follow with no gap. When rsp_chan stalls, the
// result register holds and one more frame is taken into the input register;
// req_chan.ready drops only when both are full. Reset clears both pipeline
// stages, the turn counter, the last angle and the home offset. Frames with a
// bad CRC report but leave state alone.
// ----------------------------------------------------------------------------
module angle_sensor_frame_unwrapper
   import asfu_pkg::*;
#(
   parameter int ANGLE_BITS = 21,
   parameter int TURN_BITS  = 16
) (
   input  logic       clock,
   input  logic       reset,
   asfu_req_if.sink   req_chan,
   asfu_rsp_if.source rsp_chan
);

   logic             s1_valid_ff;
   action_type       s1_action_ff;
   byte_type         s1_high_ff, s1_mid_ff, s1_low_ff, s1_crc_ff;
   logic             s1_advance;

   logic             out_valid_ff;
   total_type        out_total_ff;
   frame_fields_type out_fields_ff;

   frame_fields_type fields;
   total_type        total_angle;
   logic             req_xfer;

   assign s1_advance     = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_action_ff <= action_type'(req_chan.action);
         s1_high_ff   <= req_chan.angle_high_byte;
         s1_mid_ff    <= req_chan.angle_mid_byte;
         s1_low_ff    <= req_chan.angle_low_status_byte;
         s1_crc_ff    <= req_chan.frame_crc;
      end
   end

   asfu_frame_decode #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_decode (
      .angle_high_byte       (s1_high_ff),
      .angle_mid_byte        (s1_mid_ff),
      .angle_low_status_byte (s1_low_ff),
      .frame_crc             (s1_crc_ff),
      .fields                (fields)
   );

   asfu_unwrap #(
      .ANGLE_BITS (ANGLE_BITS),
      .TURN_BITS  (TURN_BITS)
   ) u_unwrap (
      .clock       (clock),
      .reset       (reset),
      .update_en   (s1_advance),
      .action      (s1_action_ff),
      .fields      (fields),
      .total_angle (total_angle)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_chan.ready) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         out_total_ff  <= total_angle;
         out_fields_ff <= fields;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.total_angle   = out_total_ff;
   assign rsp_chan.crc_ok        = out_fields_ff.crc_ok;
   assign rsp_chan.frame_angle   = out_fields_ff.frame_angle;
   assign rsp_chan.sensor_status = out_fields_ff.sensor_status;

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !s1_valid_ff && !out_valid_ff)
      else $error("pipeline not empty after reset");

   a_input_lands: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> s1_valid_ff)
      else $error("input transfer lost");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_advance |=> s1_valid_ff && $stable(s1_high_ff)
                                     && $stable(s1_crc_ff) && $stable(s1_action_ff))
      else $error("stalled frame overwritten");

endmodule
`default_nettype wire

### verif/asfu_tb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asfu_tb_pkg
// Frame CRC used by the angle sensor frame unwrapper testbench: the stimulus
// uses it to build frames and the checker uses it to predict crc_ok.
// ----------------------------------------------------------------------------
package asfu_tb_pkg;
   import asfu_pkg::*;

   localparam byte_type CRC8_POLY = 8'h07;

   // CRC-8, init 0, MSB first, no final XOR, bit-serial over the data word
   function automatic byte_type frame_crc8(word_type word);
      byte_type crc;
      crc = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (crc[BYTE_BITS-1] ^ word[i]) begin
            crc = {crc[BYTE_BITS-2:0], 1'b0} ^ CRC8_POLY;
         end else begin
            crc = {crc[BYTE_BITS-2:0], 1'b0};
         end
      end
      return crc;
   endfunction

endpackage
`default_nettype wire

### verif/angle_sensor_frame_unwrapper_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// angle_sensor_frame_unwrapper_checker
// Watches the frame and result channels, predicts the multi-turn result of
// each accepted frame from its own copy of last angle, turn count and home
// offset, and compares each result transfer field by field, in order.
// ----------------------------------------------------------------------------
module angle_sensor_frame_unwrapper_checker
   import asfu_pkg::*;
   import asfu_tb_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   asfu_req_if    req_mon,
   asfu_rsp_if    rsp_mon,
   output int     fail_count,
   output int     pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ANGLE_BITS = 21;
   localparam int TURN_BITS  = 16;

   localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
   localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};
   localparam longint COUNTS_PER_TURN = longint'(1) << ANGLE_BITS;
   localparam longint HALF_TURN       = COUNTS_PER_TURN / 2;

   typedef struct packed {
      total_type  total_angle;
      logic       crc_ok;
      raw_type    frame_angle;
      status_type sensor_status;
   } angle_result_type;

   angle_result_type expected_angles[$];

   raw_type                      last_angle_q;
   logic signed [TURN_BITS-1:0]  turn_count_q;
   raw_type                      home_offset_q;

   int bad_results = 0;

   assign fail_count = bad_results;

   task automatic unwrap_frame(input action_type act, input word_type word,
                               input byte_type rx_crc, output angle_result_type res);
      raw_type angle;
      logic    ok;
      longint  diff;
      longint  total;
      angle = word[WORD_BITS-1:STATUS_BITS];
      ok    = (frame_crc8(word) == rx_crc);
      if (ok) begin
         if (act == ACTION_HOME) begin
            turn_count_q  = '0;
            home_offset_q = angle;
         end else begin
            diff = longint'(angle) - longint'(last_angle_q);
            if (diff > HALF_TURN) begin
               if (turn_count_q != TURN_MIN) turn_count_q = turn_count_q - TURN_BITS'(1);
            end else if (diff < -HALF_TURN) begin
               if (turn_count_q != TURN_MAX) turn_count_q = turn_count_q + TURN_BITS'(1);
            end
            last_angle_q = angle;
         end
      end
      total = longint'(last_angle_q) + longint'(turn_count_q) * COUNTS_PER_TURN
              - longint'(home_offset_q);
      res.total_angle   = total_type'(total);
      res.crc_ok        = ok;
      res.frame_angle   = angle;
      res.sensor_status = word[STATUS_BITS-1:0];
   endtask

   task automatic report(input string field, input longint want, input longint got);
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
   endtask

   always @(posedge clock) begin
      angle_result_type want;
      angle_result_type got;
      angle_result_type next;
      logic             wrong;
      if (reset) begin
         expected_angles.delete();
         last_angle_q  = '0;
         turn_count_q  = '0;
         home_offset_q = '0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.total_angle   = rsp_mon.total_angle;
            got.crc_ok        = rsp_mon.crc_ok;
            got.frame_angle   = rsp_mon.frame_angle;
            got.sensor_status = rsp_mon.sensor_status;
            if (expected_angles.size() == 0) begin
               $display("%0t: total_angle expected none actual %0d",
                        $time, $signed(got.total_angle));
               bad_results++;
            end else begin
               want  = expected_angles.pop_front();
               wrong = 1'b0;
               if (got.total_angle !== want.total_angle) begin
                  report("total_angle", longint'($signed(want.total_angle)),
                         longint'($signed(got.total_angle)));
                  wrong = 1'b1;
               end
               if (got.crc_ok !== want.crc_ok) begin
                  report("crc_ok", longint'(want.crc_ok), longint'(got.crc_ok));
                  wrong = 1'b1;
               end
               if (got.frame_angle !== want.frame_angle) begin
                  report("frame_angle", longint'(want.frame_angle),
                         longint'(got.frame_angle));
                  wrong = 1'b1;
               end
               if (got.sensor_status !== want.sensor_status) begin
                  report("sensor_status", longint'(want.sensor_status),
                         longint'(got.sensor_status));
                  wrong = 1'b1;
               end
               if (wrong) bad_results++;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            unwrap_frame(action_type'(req_mon.action),
                         {req_mon.angle_high_byte, req_mon.angle_mid_byte,
                          req_mon.angle_low_status_byte},
                         req_mon.frame_crc, next);
            expected_angles.push_back(next);
         end
      end
      pending_results <= expected_angles.size();
   end

endmodule
`default_nettype wire

### verif/angle_sensor_frame_unwrapper_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// angle_sensor_frame_unwrapper_tb
// Drives sensor frames into the unwrapper: a directed set of wrap, half-turn,
// CRC-failure and home cases, a short sweep of the turn counter in both
// directions, then random frames with random idle bursts on both channels.
// The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module angle_sensor_frame_unwrapper_tb
   import asfu_pkg::*;
   import asfu_tb_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  RANDOM_FRAMES = 520;
   localparam int  QUIET_FRAMES  = 100;
   localparam int  SWEEP_TURNS   = 10;
   localparam int  CYCLE_LIMIT   = 1000000;
   localparam int  TAIL_CYCLES   = 8;

   localparam raw_type ANGLE_ZERO = 21'h00000;
   localparam raw_type ANGLE_HALF = 21'h100000;
   localparam raw_type ANGLE_MAX  = 21'h1FFFFF;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_results;
   int   cycles = 0;
   bit   req_idle_on = 1'b1;
   bit   rsp_idle_on = 1'b1;

   asfu_req_if req_chan ();
   asfu_rsp_if rsp_chan ();

   angle_sensor_frame_unwrapper u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   angle_sensor_frame_unwrapper_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_idle_on && $urandom_range(0, 9) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
      end
   end

   task automatic put_frame(input action_type act, input word_type word, input byte_type crc);
      if (req_idle_on && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_chan.valid                 <= 1'b1;
      req_chan.action                <= act;
      req_chan.angle_high_byte       <= word[23:16];
      req_chan.angle_mid_byte        <= word[15:8];
      req_chan.angle_low_status_byte <= word[7:0];
      req_chan.frame_crc             <= crc;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic send_frame(input action_type act, input raw_type angle, input logic crc_good);
      word_type word;
      byte_type crc;
      word = {angle, status_type'($urandom_range(0, 7))};
      crc  = frame_crc8(word);
      if (!crc_good) crc = crc ^ byte_type'($urandom_range(1, 255));
      put_frame(act, word, crc);
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   function automatic raw_type next_angle(raw_type prev);
      case ($urandom_range(0, 5))
         0: return prev + raw_type'($urandom_range(0, 2000)) - raw_type'(1000);
         1: return prev + ANGLE_HALF + raw_type'($urandom_range(0, 2)) - raw_type'(1);
         2: return prev - ANGLE_HALF + raw_type'($urandom_range(0, 2)) - raw_type'(1);
         3: return raw_type'($urandom());
         4: begin
            case ($urandom_range(0, 3))
               0: return ANGLE_ZERO;
               1: return ANGLE_MAX;
               2: return ANGLE_HALF;
               default: return ANGLE_HALF - raw_type'(1);
            endcase
         end
         default: return prev + raw_type'($urandom_range(21'h080000, 21'h1FFFFF));
      endcase
   endfunction

   initial begin
      raw_type prev_angle;
      int      pick;
      reset                          <= 1'b1;
      req_chan.valid                 <= 1'b0;
      req_chan.action                <= ACTION_SAMPLE;
      req_chan.angle_high_byte       <= '0;
      req_chan.angle_mid_byte        <= '0;
      req_chan.angle_low_status_byte <= '0;
      req_chan.frame_crc             <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: wraps, exact half turns, CRC failures, home
      put_frame(ACTION_SAMPLE, 24'h000000, frame_crc8(24'h000000));
      put_frame(ACTION_SAMPLE, 24'hFFFFFF, frame_crc8(24'hFFFFFF));
      send_frame(ACTION_SAMPLE, ANGLE_ZERO, 1'b1);
      send_frame(ACTION_SAMPLE, ANGLE_HALF, 1'b1);
      send_frame(ACTION_SAMPLE, ANGLE_ZERO, 1'b1);
      send_frame(ACTION_SAMPLE, ANGLE_HALF + raw_type'(1), 1'b1);
      send_frame(ACTION_SAMPLE, ANGLE_ZERO, 1'b1);
      send_frame(ACTION_SAMPLE, ANGLE_HALF + raw_type'(1), 1'b1);
      send_frame(ACTION_SAMPLE, raw_type'(1), 1'b1);
      send_frame(ACTION_SAMPLE, ANGLE_MAX, 1'b0);
      send_frame(ACTION_HOME, 21'h0ABCDE, 1'b0);
      send_frame(ACTION_HOME, 21'h0ABCDE, 1'b1);
      send_frame(ACTION_SAMPLE, ANGLE_MAX, 1'b1);
      send_frame(ACTION_SAMPLE, ANGLE_HALF - raw_type'(1), 1'b1);
      put_frame(ACTION_HOME, 24'hFFFFFF, 8'hFF);
      put_frame(ACTION_SAMPLE, 24'hFFFFFF, frame_crc8(24'hFFFFFF) ^ 8'hFF);
      put_frame(ACTION_SAMPLE, 24'h000000, 8'hFF);
      send_frame(ACTION_HOME, ANGLE_ZERO, 1'b1);
      drain_results();

      // turn counter a few turns down, then a few turns up
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      send_frame(ACTION_SAMPLE, ANGLE_ZERO, 1'b1);
      send_frame(ACTION_HOME, ANGLE_MAX, 1'b1);
      for (int i = 0; i < SWEEP_TURNS; i++) begin
         send_frame(ACTION_SAMPLE, ANGLE_MAX, 1'b1);
         send_frame(ACTION_SAMPLE, ANGLE_HALF, 1'b1);
         send_frame(ACTION_SAMPLE, ANGLE_ZERO, 1'b1);
      end
      send_frame(ACTION_HOME, ANGLE_ZERO, 1'b1);
      for (int i = 0; i < SWEEP_TURNS; i++) begin
         send_frame(ACTION_SAMPLE, ANGLE_HALF, 1'b1);
         send_frame(ACTION_SAMPLE, ANGLE_MAX, 1'b1);
         send_frame(ACTION_SAMPLE, ANGLE_ZERO, 1'b1);
      end
      send_frame(ACTION_SAMPLE, ANGLE_HALF, 1'b1);
      send_frame(ACTION_SAMPLE, ANGLE_MAX, 1'b1);
      send_frame(ACTION_HOME, ANGLE_ZERO, 1'b1);
      drain_results();

      // random frames, mostly with a good CRC
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      prev_angle  = ANGLE_ZERO;
      for (int n = 0; n < RANDOM_FRAMES; n++) begin
         if (n == RANDOM_FRAMES / 2) drain_results();
         if (n == RANDOM_FRAMES - QUIET_FRAMES) begin
            req_idle_on = 1'b0;
            rsp_idle_on = 1'b0;
         end
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            put_frame(action_type'($urandom_range(0, 1)), word_type'($urandom()),
                      byte_type'($urandom()));
         end else if (pick < 16) begin
            send_frame(ACTION_HOME, next_angle(prev_angle), 1'b1);
         end else if (pick < 24) begin
            send_frame(ACTION_SAMPLE, next_angle(prev_angle), 1'b0);
         end else begin
            prev_angle = next_angle(prev_angle);
            send_frame(ACTION_SAMPLE, prev_angle, 1'b1);
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_results == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
`default_nettype wire
